// File: hw/rtl/dgll_pkg.sv
// dgll_pkg: shared widths, register indexes, controller states and the
// command/status structs of the diagonal Gaussian scorer.
// No dependencies.
package dgll_pkg;

  // field widths
  localparam int IdxW      = 6;
  localparam int ValW      = 16;
  localparam int GradW     = 32;
  localparam int DistW     = 48;
  localparam int DimsW     = 7;
  localparam int LogNormW  = 32;
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 32;

  // divider numerator widths: mag << 16 and mag^2 << 8
  localparam int GradNumW  = 32;
  localparam int TermNumW  = 40;

  // request kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_SCORE = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_DIMS     = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_LOG_NORM = 1'b1;

  // saturation limits of the gradient
  localparam logic [GradW-1:0] GRAD_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [GradW-1:0] GRAD_NEG_MAG = 32'h8000_0000;

  // controller states
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_FETCH = 6'b000010,
    ST_MUL   = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_ACC   = 6'b010000,
    ST_OUT   = 6'b100000
  } dgll_state_e;

  // controller to datapath
  typedef struct packed {
    logic wr_entry;   // write one table entry
    logic take;       // capture a sample, read its table entry
    logic prep;       // difference, magnitude, variance fix
    logic div_start;  // square and launch both dividers
    logic acc;        // gradient saturation and distance update
    logic out_load;   // fill the output register, advance the vector
  } dgll_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic out_free;
  } dgll_sts_t;

endpackage

// File: hw/rtl/dgll_in_if.sv
// dgll_in_if: request channel, valid/ready plus load or score payload.
// Depends on dgll_pkg.
interface dgll_in_if;
  logic                            valid;
  logic                            ready;
  logic                            req_type;
  logic [dgll_pkg::IdxW-1:0]       entry_index;
  logic signed [dgll_pkg::ValW-1:0] mean_value;
  logic [dgll_pkg::ValW-1:0]       variance_value;
  logic signed [dgll_pkg::ValW-1:0] sample_value;

  modport source (
    output valid, req_type, entry_index, mean_value, variance_value, sample_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, entry_index, mean_value, variance_value, sample_value,
    output ready
  );
endinterface

// File: hw/rtl/dgll_out_if.sv
// dgll_out_if: result channel, valid/ready plus one scored element.
// Depends on dgll_pkg.
interface dgll_out_if;
  logic                               valid;
  logic                               ready;
  logic [dgll_pkg::IdxW-1:0]          dim_index;
  logic signed [dgll_pkg::GradW-1:0]  grad_logp;
  logic                               last;
  logic [dgll_pkg::DistW-1:0]         mahalanobis_sq;
  logic signed [dgll_pkg::DistW-1:0]  log_density;
  logic                               saturated;

  modport source (
    output valid, dim_index, grad_logp, last, mahalanobis_sq, log_density, saturated,
    input  ready
  );
  modport sink (
    input  valid, dim_index, grad_logp, last, mahalanobis_sq, log_density, saturated,
    output ready
  );
endinterface

// File: hw/rtl/dgll_ram.sv
// dgll_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
module dgll_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/dgll_div.sv
// dgll_div: restoring radix-2 unsigned divider, one quotient bit per cycle.
// Divisor is 16 bits and nonzero. No dependencies.
module dgll_div #(
  parameter int NumW = 40
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [15:0]     den_i,
  output logic            busy_o,
  output logic [NumW-1:0] quo_o
);

  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] num_q, num_d;
  logic [15:0]     rem_q, rem_d;
  logic [15:0]     den_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [16:0]     rem_sh;
  logic [17:0]     diff;

  // one shift-subtract step
  always_comb begin
    rem_sh = {rem_q, num_q[NumW-1]};
    diff   = {1'b0, rem_sh} - {2'b00, den_q};
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      num_d  = num_i;
      rem_d  = '0;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[17]) begin
        rem_d = diff[15:0];
        num_d = {num_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[15:0];
        num_d = {num_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = num_q;

endmodule

// File: hw/rtl/dgll_ctrl.sv
// dgll_ctrl: sequencer of the scorer, one-hot state machine that issues
// datapath commands. Depends on dgll_pkg.
module dgll_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_req_type_i,
  input  dgll_pkg::dgll_sts_t sts_i,
  output logic                in_ready_o,
  output dgll_pkg::dgll_cmd_t cmd_o
);

  dgll_pkg::dgll_state_e state_q, state_d;
  logic in_beat;

  assign in_ready_o = (state_q == dgll_pkg::ST_IDLE);
  assign in_beat    = in_valid_i && in_ready_o;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      dgll_pkg::ST_IDLE: begin
        if (in_beat) begin
          if (in_req_type_i == dgll_pkg::REQ_SCORE) begin
            cmd_o.take = 1'b1;
            state_d    = dgll_pkg::ST_FETCH;
          end else begin
            cmd_o.wr_entry = 1'b1;
          end
        end
      end
      dgll_pkg::ST_FETCH: begin
        cmd_o.prep = 1'b1;
        state_d    = dgll_pkg::ST_MUL;
      end
      dgll_pkg::ST_MUL: begin
        cmd_o.div_start = 1'b1;
        state_d         = dgll_pkg::ST_DIV;
      end
      dgll_pkg::ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = dgll_pkg::ST_ACC;
        end
      end
      dgll_pkg::ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = dgll_pkg::ST_OUT;
      end
      dgll_pkg::ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = dgll_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dgll_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dgll_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hw/rtl/dgll_dp.sv
// dgll_dp: datapath of the scorer: model table, config registers, two
// dividers, distance accumulator and output register.
// Depends on dgll_pkg, dgll_ram, dgll_div.
module dgll_dp #(
  parameter int MaxDims = 64
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration
  input  logic                                   cfg_we_i,
  input  logic [dgll_pkg::CfgIdxW-1:0]           cfg_idx_i,
  input  logic [dgll_pkg::CfgDataW-1:0]          cfg_wdata_i,
  // request payload
  input  logic [dgll_pkg::IdxW-1:0]              entry_index_i,
  input  logic signed [dgll_pkg::ValW-1:0]       mean_value_i,
  input  logic [dgll_pkg::ValW-1:0]              variance_value_i,
  input  logic signed [dgll_pkg::ValW-1:0]       sample_value_i,
  // controller link
  input  dgll_pkg::dgll_cmd_t                    cmd_i,
  output dgll_pkg::dgll_sts_t                    sts_o,
  // result channel
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [dgll_pkg::IdxW-1:0]              dim_index_o,
  output logic signed [dgll_pkg::GradW-1:0]      grad_logp_o,
  output logic                                   last_o,
  output logic [dgll_pkg::DistW-1:0]             mahalanobis_sq_o,
  output logic signed [dgll_pkg::DistW-1:0]      log_density_o,
  output logic                                   saturated_o
);

  localparam int AddrW = (MaxDims > 1) ? $clog2(MaxDims) : 1;
  localparam int EffW  = ($clog2(MaxDims + 1) > dgll_pkg::DimsW) ?
                         $clog2(MaxDims + 1) : dgll_pkg::DimsW;
  localparam int ValW  = dgll_pkg::ValW;
  localparam int DistW = dgll_pkg::DistW;
  localparam int GradW = dgll_pkg::GradW;

  // configuration registers
  logic [dgll_pkg::DimsW-1:0]    dims_q;
  logic [dgll_pkg::LogNormW-1:0] log_norm_q;

  // vector state
  logic [AddrW-1:0] count_q;
  logic [DistW-1:0] acc_q;
  logic             sat_flag_q;

  // per-element working registers
  logic signed [ValW-1:0] x_q;
  logic [ValW-1:0]        mag_q;
  logic                   neg_q;
  logic [ValW-1:0]        var_q;
  logic [GradW-1:0]       grad_q;
  logic                   sat_cur_q;

  // output register
  logic                   out_valid_q;
  logic [dgll_pkg::IdxW-1:0] o_idx_q;
  logic [GradW-1:0]       o_grad_q;
  logic                   o_last_q;
  logic [DistW-1:0]       o_dist_q;
  logic [DistW-1:0]       o_ld_q;
  logic                   o_sat_q;

  // table signals
  logic                   wr_ok;
  logic [2*ValW-1:0]      rd_data;
  logic signed [ValW-1:0] tbl_mean;
  logic [ValW-1:0]        tbl_var;

  // arithmetic signals
  logic signed [ValW:0]           diff;
  logic [ValW:0]                  diff_abs;
  logic [2*ValW-1:0]              sq;
  logic [dgll_pkg::GradNumW-1:0]  quo_grad;
  logic [dgll_pkg::TermNumW-1:0]  quo_term;
  logic                           busy_grad, busy_term;
  logic [GradW-1:0]               grad_d;
  logic                           grad_sat;
  logic [DistW:0]                 acc_sum;
  logic [DistW-1:0]               acc_d;
  logic                           acc_sat;
  logic signed [DistW:0]          ld_full;
  logic [DistW-1:0]               ld_val;
  logic                           ld_sat;
  logic [EffW-1:0]                eff_dims;
  logic [EffW-1:0]                count_p1;
  logic                           is_last;

  // model table, mean in the upper half and variance in the lower
  assign wr_ok = cmd_i.wr_entry && (32'(entry_index_i) < 32'(MaxDims));

  dgll_ram #(
    .Width (2 * ValW),
    .Depth (MaxDims)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_ok),
    .waddr_i (AddrW'(entry_index_i)),
    .wdata_i ({mean_value_i, variance_value_i}),
    .re_i    (cmd_i.take),
    .raddr_i (count_q),
    .rdata_o (rd_data)
  );

  assign tbl_mean = rd_data[2*ValW-1:ValW];
  assign tbl_var  = rd_data[ValW-1:0];

  // difference and magnitude
  assign diff     = {tbl_mean[ValW-1], tbl_mean} - {x_q[ValW-1], x_q};
  assign diff_abs = diff[ValW] ? (ValW+1)'(-diff) : diff;

  // square of the magnitude feeds the distance divider
  assign sq = (2*ValW)'(mag_q) * (2*ValW)'(mag_q);

  dgll_div #(
    .NumW (dgll_pkg::GradNumW)
  ) u_div_grad (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   ({mag_q, 16'h0000}),
    .den_i   (var_q),
    .busy_o  (busy_grad),
    .quo_o   (quo_grad)
  );

  dgll_div #(
    .NumW (dgll_pkg::TermNumW)
  ) u_div_term (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   ({sq, 8'h00}),
    .den_i   (var_q),
    .busy_o  (busy_term),
    .quo_o   (quo_term)
  );

  // gradient sign and saturation
  always_comb begin
    grad_sat = 1'b0;
    if (!neg_q) begin
      if (quo_grad[GradW-1]) begin
        grad_d   = dgll_pkg::GRAD_POS_MAX;
        grad_sat = 1'b1;
      end else begin
        grad_d = quo_grad;
      end
    end else begin
      if (quo_grad > dgll_pkg::GRAD_NEG_MAG) begin
        grad_d   = dgll_pkg::GRAD_NEG_MAG;
        grad_sat = 1'b1;
      end else begin
        grad_d = GradW'(-quo_grad);
      end
    end
  end

  // saturating distance accumulate
  assign acc_sum = {1'b0, acc_q} + (DistW+1)'(quo_term);
  assign acc_sat = acc_sum[DistW];
  assign acc_d   = acc_sat ? {DistW{1'b1}} : acc_sum[DistW-1:0];

  // log density, only the low side can overflow
  assign ld_full = (DistW+1)'(signed'(log_norm_q)) - signed'({2'b00, acc_q[DistW-1:1]});
  assign ld_sat  = ld_full[DistW] != ld_full[DistW-1];
  assign ld_val  = ld_sat ? {1'b1, {(DistW-1){1'b0}}} : ld_full[DistW-1:0];

  // end of vector against the clamped dimension count
  always_comb begin
    if (dims_q == '0) begin
      eff_dims = EffW'(1);
    end else if (EffW'(dims_q) > EffW'(MaxDims)) begin
      eff_dims = EffW'(MaxDims);
    end else begin
      eff_dims = EffW'(dims_q);
    end
  end
  assign count_p1 = EffW'(count_q) + EffW'(1);
  assign is_last  = count_p1 >= eff_dims;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q     <= dgll_pkg::DimsW'(1);
      log_norm_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dgll_pkg::CFG_DIMS:     dims_q     <= cfg_wdata_i[dgll_pkg::DimsW-1:0];
        dgll_pkg::CFG_LOG_NORM: log_norm_q <= cfg_wdata_i[dgll_pkg::LogNormW-1:0];
        default: begin
        end
      endcase
    end
  end

  // vector state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      acc_q       <= '0;
      sat_flag_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.acc) begin
        acc_q <= acc_d;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
        if (is_last) begin
          count_q    <= '0;
          acc_q      <= '0;
          sat_flag_q <= 1'b0;
        end else begin
          count_q    <= count_q + AddrW'(1);
          sat_flag_q <= sat_flag_q | sat_cur_q;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // element working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      x_q <= sample_value_i;
    end
    if (cmd_i.prep) begin
      neg_q <= diff[ValW];
      mag_q <= diff_abs[ValW-1:0];
      var_q <= (tbl_var == '0) ? ValW'(1) : tbl_var;
    end
    if (cmd_i.acc) begin
      grad_q    <= grad_d;
      sat_cur_q <= grad_sat | acc_sat;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      o_idx_q  <= dgll_pkg::IdxW'(count_q);
      o_grad_q <= grad_q;
      o_last_q <= is_last;
      o_dist_q <= is_last ? acc_q : '0;
      o_ld_q   <= is_last ? ld_val : '0;
      o_sat_q  <= sat_flag_q | sat_cur_q | (is_last & ld_sat);
    end
  end

  assign sts_o.div_done = !busy_grad && !busy_term;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign dim_index_o      = o_idx_q;
  assign grad_logp_o      = o_grad_q;
  assign last_o           = o_last_q;
  assign mahalanobis_sq_o = o_dist_q;
  assign log_density_o    = o_ld_q;
  assign saturated_o      = o_sat_q;

endmodule

// File: hw/rtl/diag_gaussian_log_likelihood.sv
// diag_gaussian_log_likelihood: top level of the diagonal Gaussian scorer.
// Depends on dgll_pkg, dgll_in_if, dgll_out_if, dgll_ctrl, dgll_dp.
//
//   channel   direction  beat contents
//   in_if     sink       load entry (index, mean, variance) or one sample
//   out_if    source     gradient per element, distance and log density on last
//   cfg       write      dims (index 0), log_norm (index 1)
//
// A load beat leaves the sequencer idle; the next beat can be accepted right after.
// A score beat waits in the divide step for the 40-step radix-2 divider for the
// distance term (the gradient divider runs alongside in 32 steps).
// The output register holds a finished result while the next beat is taken;
// a stalled result holds the sequencer only at its final step.
// Reset is asynchronous, active low, and clears the vector state; the model
// table is not cleared and must be loaded before scoring.
module diag_gaussian_log_likelihood #(
  parameter int MAX_DIMS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  dgll_in_if.sink                       in_if,
  dgll_out_if.source                    out_if,
  input  logic                          cfg_we_i,
  input  logic [dgll_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dgll_pkg::CfgDataW-1:0] cfg_wdata_i
);

  dgll_pkg::dgll_cmd_t cmd;
  dgll_pkg::dgll_sts_t sts;
  logic                in_ready;

  assign in_if.ready = in_ready;

  // sequencer
  dgll_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_if.valid),
    .in_req_type_i (in_if.req_type),
    .sts_i         (sts),
    .in_ready_o    (in_ready),
    .cmd_o         (cmd)
  );

  // datapath
  dgll_dp #(
    .MaxDims (MAX_DIMS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .entry_index_i    (in_if.entry_index),
    .mean_value_i     (in_if.mean_value),
    .variance_value_i (in_if.variance_value),
    .sample_value_i   (in_if.sample_value),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_if.valid),
    .out_ready_i      (out_if.ready),
    .dim_index_o      (out_if.dim_index),
    .grad_logp_o      (out_if.grad_logp),
    .last_o           (out_if.last),
    .mahalanobis_sq_o (out_if.mahalanobis_sq),
    .log_density_o    (out_if.log_density),
    .saturated_o      (out_if.saturated)
  );

endmodule

// File: hw/rtl/dgll_checker.sv
// dgll_checker: port-level assertions of the scorer, bound to the top level.
// Depends on dgll_pkg and diag_gaussian_log_likelihood.
module dgll_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              in_req_type_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic [dgll_pkg::IdxW-1:0]         dim_index_i,
  input logic [dgll_pkg::GradW-1:0]        grad_logp_i,
  input logic                              last_i,
  input logic [dgll_pkg::DistW-1:0]        mahalanobis_sq_i,
  input logic [dgll_pkg::DistW-1:0]        log_density_i
);

  // a score beat occupies the block, the next beat waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && in_req_type_i == dgll_pkg::REQ_SCORE) |=> !in_ready_i)
    else $error("request accepted while a score is in progress");

  // after a load beat the request channel is ready again in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && in_req_type_i == dgll_pkg::REQ_LOAD) |=> in_ready_i)
    else $error("load beat held the request channel");

  // vector totals appear only on the last element
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !last_i) |-> (mahalanobis_sq_i == '0 && log_density_i == '0))
    else $error("distance or log density on a non-last element");

  // a stalled result beat holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(dim_index_i) && $stable(grad_logp_i) && $stable(last_i)
       && $stable(mahalanobis_sq_i) && $stable(log_density_i)))
    else $error("result beat changed while stalled");

endmodule

bind diag_gaussian_log_likelihood dgll_checker u_dgll_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_if.valid),
  .in_ready_i       (in_if.ready),
  .in_req_type_i    (in_if.req_type),
  .out_valid_i      (out_if.valid),
  .out_ready_i      (out_if.ready),
  .dim_index_i      (out_if.dim_index),
  .grad_logp_i      (out_if.grad_logp),
  .last_i           (out_if.last),
  .mahalanobis_sq_i (out_if.mahalanobis_sq),
  .log_density_i    (out_if.log_density)
);

// File: tb/tb_top.sv
// tb_top: self-checking bench for diag_gaussian_log_likelihood, with a scoring
// tracker class, valid/ready drivers with random gaps and a cycle watchdog.
// Depends on dgll_pkg, dgll_in_if, dgll_out_if and the block's top level.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dgll_pkg::*;

  localparam int MAX_DIMS = 64;
  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES = 400;
  localparam longint unsigned DIST_MAX = 64'h0000_FFFF_FFFF_FFFF;
  localparam longint LOGD_MIN = -(64'sd1 <<< 47);
  localparam longint LOGD_MAX = (64'sd1 <<< 47) - 1;

  typedef struct packed {
    logic                   req_type;
    logic [IdxW-1:0]        entry;
    logic signed [ValW-1:0] mean;
    logic [ValW-1:0]        variance;
    logic signed [ValW-1:0] sample;
  } req_beat_t;

  typedef struct packed {
    logic [IdxW-1:0]         dim;
    logic signed [GradW-1:0] grad;
    logic                    last;
    logic [DistW-1:0]        dist_sq;
    logic signed [DistW-1:0] logd;
    logic                    sat;
  } elem_result_t;

  // tracks model tables and vector state, predicts and checks scored elements
  class gauss_score_tracker;
    logic signed [ValW-1:0] mean_tab [MAX_DIMS];
    logic [ValW-1:0]        var_tab [MAX_DIMS];
    bit                     loaded [MAX_DIMS];
    int unsigned            elem_count;
    longint unsigned        dist_acc;
    bit                     sat_sticky;
    bit [DimsW-1:0]         dims_reg;
    bit signed [LogNormW-1:0] log_norm_reg;
    elem_result_t           pending_elements[$];
    int                     mismatches;

    function new();
      elem_count = 0;
      dist_acc = 0;
      sat_sticky = 0;
      dims_reg = 1;
      log_norm_reg = 0;
      mismatches = 0;
      foreach (loaded[k]) loaded[k] = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_DIMS:     dims_reg = data[DimsW-1:0];
        CFG_LOG_NORM: log_norm_reg = data;
        default: ;
      endcase
    endfunction

    // dims of zero acts as one, above the table size as the table size
    function int unsigned active_dims();
      if (dims_reg == 0) return 1;
      if (dims_reg > MAX_DIMS) return MAX_DIMS;
      return dims_reg;
    endfunction

    function int unsigned next_entry();
      return (elem_count >= MAX_DIMS) ? MAX_DIMS - 1 : elem_count;
    endfunction

    // apply one accepted request beat, queue the element a score beat produces
    function void take_beat(req_beat_t b);
      int unsigned     e;
      longint          mean_v, x, diff, ld;
      longint unsigned mag, q, term, v;
      bit              over;
      elem_result_t    r;
      if (b.req_type == REQ_LOAD) begin
        if (b.entry < MAX_DIMS) begin
          mean_tab[b.entry] = b.mean;
          var_tab[b.entry] = b.variance;
          loaded[b.entry] = 1;
        end
        return;
      end
      e = next_entry();
      mean_v = mean_tab[e];
      v = var_tab[e];
      // zero variance is taken as one
      if (v == 0) v = 1;
      x = b.sample;
      diff = mean_v - x;
      mag = (diff < 0) ? -diff : diff;
      over = 0;
      // gradient, truncated toward zero and saturated
      q = (mag << 16) / v;
      if (diff >= 0) begin
        if (q > 64'h7FFF_FFFF) begin
          q = 64'h7FFF_FFFF;
          over = 1;
        end
      end else begin
        if (q > 64'h8000_0000) begin
          q = 64'h8000_0000;
          over = 1;
        end
        q = -q;
      end
      r.grad = q[GradW-1:0];
      // distance term, saturating accumulate
      term = ((mag * mag) << 8) / v;
      if (term > DIST_MAX - dist_acc) begin
        dist_acc = DIST_MAX;
        over = 1;
      end else begin
        dist_acc += term;
      end
      r.dim = e[IdxW-1:0];
      r.last = (elem_count + 1 >= active_dims());
      r.dist_sq = '0;
      r.logd = '0;
      if (r.last) begin
        ld = longint'(log_norm_reg) - longint'(dist_acc >> 1);
        if (ld < LOGD_MIN) begin
          ld = LOGD_MIN;
          over = 1;
        end
        if (ld > LOGD_MAX) begin
          ld = LOGD_MAX;
          over = 1;
        end
        r.dist_sq = dist_acc[DistW-1:0];
        r.logd = ld[DistW-1:0];
      end
      if (over) sat_sticky = 1;
      r.sat = sat_sticky;
      // vector state clears after the last element
      if (r.last) begin
        elem_count = 0;
        dist_acc = 0;
        sat_sticky = 0;
      end else begin
        elem_count++;
      end
      pending_elements.push_back(r);
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
        mismatches++;
      end
    endfunction

    // compare one result beat against the oldest predicted element
    function void match_element(elem_result_t got);
      elem_result_t want;
      if (pending_elements.size() == 0) begin
        $error("result beat with nothing pending, dim_index %0d", got.dim);
        mismatches++;
        return;
      end
      want = pending_elements.pop_front();
      check_field("dim_index", want.dim, got.dim);
      check_field("grad_logp", want.grad, got.grad);
      check_field("last", want.last, got.last);
      check_field("mahalanobis_sq", want.dist_sq, got.dist_sq);
      check_field("log_density", want.logd, got.logd);
      check_field("saturated", want.sat, got.sat);
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  dgll_in_if  in_if();
  dgll_out_if out_if();

  gauss_score_tracker sb = new();

  bit no_idle = 0;
  bit long_hold_req = 0;
  int idle_cycles = 0;

  diag_gaussian_log_likelihood #(
    .MAX_DIMS(MAX_DIMS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if),
    .out_if     (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: too long without any beat ends the run
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("diag_gaussian_log_likelihood verification failed");
      $finish;
    end
  end

  // result side: random stalls, one long hold on request
  initial begin
    elem_result_t got;
    int           wait_cycles;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      wait_cycles = no_idle ? 0 : $urandom_range(0, 3);
      if (long_hold_req) begin
        long_hold_req = 0;
        wait_cycles = HOLD_CYCLES;
      end
      if (wait_cycles != 0) begin
        out_if.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (out_if.valid !== 1'b1);
      got.dim     = out_if.dim_index;
      got.grad    = out_if.grad_logp;
      got.last    = out_if.last;
      got.dist_sq = out_if.mahalanobis_sq;
      got.logd    = out_if.log_density;
      got.sat     = out_if.saturated;
      sb.match_element(got);
    end
  end

  // offer one request beat after a random gap, return once it is taken
  task automatic send_beat(req_beat_t b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.req_type       <= b.req_type;
    in_if.entry_index    <= b.entry;
    in_if.mean_value     <= b.mean;
    in_if.variance_value <= b.variance;
    in_if.sample_value   <= b.sample;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    sb.take_beat(b);
  endtask

  task automatic load_entry(int unsigned e, logic [ValW-1:0] m, logic [ValW-1:0] v);
    req_beat_t b;
    b.req_type = REQ_LOAD;
    b.entry = e[IdxW-1:0];
    b.mean = m;
    b.variance = v;
    b.sample = ValW'($urandom());
    send_beat(b);
  endtask

  task automatic score_sample(logic [ValW-1:0] x);
    req_beat_t b;
    b.req_type = REQ_SCORE;
    b.entry = IdxW'($urandom());
    b.mean = ValW'($urandom());
    b.variance = ValW'($urandom());
    b.sample = x;
    send_beat(b);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  // drain all pending elements, then let a load or score finish inside
  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.pending_elements.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [ValW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return '0;
      default: return ValW'($urandom());
    endcase
  endfunction

  function automatic logic [ValW-1:0] pick_variance();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      3, 4:    return ValW'($urandom_range(1, 255));
      default: return ValW'($urandom());
    endcase
  endfunction

  // extremes, zero variance, dims change mid-vector, out-of-range dims
  task automatic run_directed();
    load_entry(0, 16'h7FFF, 16'd1);
    score_sample(16'h8000);
    load_entry(0, 16'h8000, 16'd0);
    score_sample(16'h7FFF);
    load_entry(0, 16'h0000, 16'hFFFF);
    score_sample(16'h0000);
    score_sample(16'h0001);
    settle();
    write_reg(CFG_DIMS, 32'd4);
    write_reg(CFG_LOG_NORM, 32'h7FFF_FFFF);
    load_entry(1, 16'd100, 16'd256);
    load_entry(2, 16'hFF00, 16'd3);
    load_entry(3, 16'h0000, 16'hFFFF);
    score_sample(16'h0000);
    score_sample(16'h7FFF);
    score_sample(16'h8000);
    score_sample(16'd5);
    score_sample(16'h1234);
    score_sample(16'hFEDC);
    settle();
    write_reg(CFG_DIMS, 32'd2);
    score_sample(16'h0040);
    settle();
    write_reg(CFG_DIMS, 32'd0);
    write_reg(CFG_LOG_NORM, 32'h8000_0000);
    score_sample(16'h7FFF);
    score_sample(16'h8000);
  endtask

  // mostly scoring with on-demand loads, some reloads of random entries
  task automatic run_random(int n, bit with_hold);
    int unsigned e;
    for (int k = 0; k < n; k++) begin
      if (with_hold && k == n / 2) long_hold_req = 1;
      e = sb.next_entry();
      if (!sb.loaded[e]) begin
        load_entry(e, pick_value(), pick_variance());
      end else if ($urandom_range(0, 4) == 0) begin
        load_entry($urandom_range(0, MAX_DIMS - 1), pick_value(), pick_variance());
      end else if ($urandom_range(0, 9) == 0) begin
        score_sample(sb.mean_tab[e]);
      end else begin
        score_sample(pick_value());
      end
    end
  endtask

  // reset, directed beats, then random phases over several settings
  initial begin
    logic [CfgDataW-1:0] dims_val, norm_val;
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_idx_i            <= CFG_DIMS;
    cfg_wdata_i          <= '0;
    in_if.valid          <= 1'b0;
    in_if.req_type       <= REQ_LOAD;
    in_if.entry_index    <= '0;
    in_if.mean_value     <= '0;
    in_if.variance_value <= '0;
    in_if.sample_value   <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (int p = 0; p < 10; p++) begin
      settle();
      case (p)
        0: begin dims_val = 32'd64;  norm_val = $urandom(); end
        1: begin dims_val = 32'd127; norm_val = 32'h7FFF_FFFF; end
        2: begin dims_val = 32'd1;   norm_val = 32'h8000_0000; end
        3: begin dims_val = 32'd65;  norm_val = $urandom(); end
        4: begin dims_val = 32'd0;   norm_val = '0; end
        default: begin dims_val = $urandom_range(1, 8); norm_val = $urandom(); end
      endcase
      write_reg(CFG_DIMS, dims_val);
      write_reg(CFG_LOG_NORM, norm_val);
      no_idle = (p % 3 == 1);
      run_random(70, p == 5);
    end
    no_idle = 0;
    settle();
    if (sb.mismatches == 0 && sb.pending_elements.size() == 0) begin
      $display("diag_gaussian_log_likelihood verification clean");
    end else begin
      $display("diag_gaussian_log_likelihood verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/dgll_pkg.sv
hw/rtl/dgll_in_if.sv
hw/rtl/dgll_out_if.sv
hw/rtl/dgll_ram.sv
hw/rtl/dgll_div.sv
hw/rtl/dgll_ctrl.sv
hw/rtl/dgll_dp.sv
hw/rtl/diag_gaussian_log_likelihood.sv
hw/rtl/dgll_checker.sv
tb/tb_top.sv
